FILE: hw/rtl/segment_intersection_point_defines.svh
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_POINT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_DEFINES_SVH

`ifndef SYNTHESIS
`define SIP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment intersection assertion failed");
`define SIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("segment intersection implication failed");
`else
`define SIP_ASSERT(label, clk, rst_n, prop)
`define SIP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/sip_pkg.sv
// shared constants and types for the segment intersection block
package sip_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned LANES          = 2;
  localparam int unsigned LANE_X         = 0;
  localparam int unsigned LANE_Y         = 1;

  typedef struct packed {
    logic hit;
    logic point_valid;
  } sip_flags_t;

endpackage

FILE: hw/rtl/sip_front.sv
// front stages: differences, cross products, orientation signs, hit and point_valid flags
module sip_front #(
  parameter int unsigned COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  input  logic signed [COORD_BITS-1:0]     ax_i,
  input  logic signed [COORD_BITS-1:0]     ay_i,
  input  logic signed [COORD_BITS-1:0]     bx_i,
  input  logic signed [COORD_BITS-1:0]     by_i,
  input  logic signed [COORD_BITS-1:0]     cx_i,
  input  logic signed [COORD_BITS-1:0]     cy_i,
  input  logic signed [COORD_BITS-1:0]     ex_i,
  input  logic signed [COORD_BITS-1:0]     ey_i,
  output logic                             valid_o,
  output sip_pkg::sip_flags_t              flags_o,
  output logic signed [COORD_BITS-1:0]     ax_o,
  output logic signed [COORD_BITS-1:0]     ay_o,
  output logic signed [COORD_BITS:0]       dax_o,
  output logic signed [COORD_BITS:0]       day_o,
  output logic signed [2*COORD_BITS+2:0]   den_o,
  output logic signed [2*COORD_BITS+2:0]   num_o
);
  import sip_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;

  // stage 1: coordinate differences
  logic                   s1_vld_r;
  logic signed [COORD_BITS-1:0] s1_ax_r, s1_ay_r;
  logic signed [DW-1:0]   dax_nxt, day_nxt, dbx_nxt, dby_nxt, cax_nxt, cay_nxt;
  logic signed [DW-1:0]   eax_nxt, eay_nxt, ebx_nxt, eby_nxt;
  logic signed [DW-1:0]   dax_r, day_r, dbx_r, dby_r, cax_r, cay_r;
  logic signed [DW-1:0]   eax_r, eay_r, ebx_r, eby_r;

  assign dax_nxt = DW'(bx_i) - DW'(ax_i);
  assign day_nxt = DW'(by_i) - DW'(ay_i);
  assign dbx_nxt = DW'(ex_i) - DW'(cx_i);
  assign dby_nxt = DW'(ey_i) - DW'(cy_i);
  assign cax_nxt = DW'(cx_i) - DW'(ax_i);
  assign cay_nxt = DW'(cy_i) - DW'(ay_i);
  assign eax_nxt = DW'(ex_i) - DW'(ax_i);
  assign eay_nxt = DW'(ey_i) - DW'(ay_i);
  assign ebx_nxt = DW'(bx_i) - DW'(cx_i);
  assign eby_nxt = DW'(by_i) - DW'(cy_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax_r <= ax_i;
    s1_ay_r <= ay_i;
    dax_r   <= dax_nxt;
    day_r   <= day_nxt;
    dbx_r   <= dbx_nxt;
    dby_r   <= dby_nxt;
    cax_r   <= cax_nxt;
    cay_r   <= cay_nxt;
    eax_r   <= eax_nxt;
    eay_r   <= eay_nxt;
    ebx_r   <= ebx_nxt;
    eby_r   <= eby_nxt;
  end

  // stage 2: products
  logic                   s2_vld_r;
  logic signed [COORD_BITS-1:0] s2_ax_r, s2_ay_r;
  logic signed [DW-1:0]   s2_dax_r, s2_day_r;
  logic signed [PW-1:0]   p_dax_cay_nxt, p_day_cax_nxt, p_dax_eay_nxt, p_day_eax_nxt;
  logic signed [PW-1:0]   p_cax_dby_nxt, p_cay_dbx_nxt, p_dbx_eby_nxt, p_dby_ebx_nxt;
  logic signed [PW-1:0]   p_dax_dby_nxt, p_day_dbx_nxt;
  logic signed [PW-1:0]   p_dax_cay_r, p_day_cax_r, p_dax_eay_r, p_day_eax_r;
  logic signed [PW-1:0]   p_cax_dby_r, p_cay_dbx_r, p_dbx_eby_r, p_dby_ebx_r;
  logic signed [PW-1:0]   p_dax_dby_r, p_day_dbx_r;

  assign p_dax_cay_nxt = dax_r * cay_r;
  assign p_day_cax_nxt = day_r * cax_r;
  assign p_dax_eay_nxt = dax_r * eay_r;
  assign p_day_eax_nxt = day_r * eax_r;
  assign p_cax_dby_nxt = cax_r * dby_r;
  assign p_cay_dbx_nxt = cay_r * dbx_r;
  assign p_dbx_eby_nxt = dbx_r * eby_r;
  assign p_dby_ebx_nxt = dby_r * ebx_r;
  assign p_dax_dby_nxt = dax_r * dby_r;
  assign p_day_dbx_nxt = day_r * dbx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ax_r     <= s1_ax_r;
    s2_ay_r     <= s1_ay_r;
    s2_dax_r    <= dax_r;
    s2_day_r    <= day_r;
    p_dax_cay_r <= p_dax_cay_nxt;
    p_day_cax_r <= p_day_cax_nxt;
    p_dax_eay_r <= p_dax_eay_nxt;
    p_day_eax_r <= p_day_eax_nxt;
    p_cax_dby_r <= p_cax_dby_nxt;
    p_cay_dbx_r <= p_cay_dbx_nxt;
    p_dbx_eby_r <= p_dbx_eby_nxt;
    p_dby_ebx_r <= p_dby_ebx_nxt;
    p_dax_dby_r <= p_dax_dby_nxt;
    p_day_dbx_r <= p_day_dbx_nxt;
  end

  // stage 3: cross sums and side tests
  logic signed [XW-1:0]   cr_abc, cr_abe, cr_ceb, num_nxt, den_nxt;
  logic                   same_ab, same_ce;
  sip_flags_t             flags_nxt;
  logic                   s3_vld_r;
  sip_flags_t             flags_r;
  logic signed [COORD_BITS-1:0] s3_ax_r, s3_ay_r;
  logic signed [DW-1:0]   s3_dax_r, s3_day_r;
  logic signed [XW-1:0]   den_r, num_r;

  assign cr_abc  = XW'(p_dax_cay_r) - XW'(p_day_cax_r);
  assign cr_abe  = XW'(p_dax_eay_r) - XW'(p_day_eax_r);
  assign num_nxt = XW'(p_cax_dby_r) - XW'(p_cay_dbx_r);
  assign cr_ceb  = XW'(p_dbx_eby_r) - XW'(p_dby_ebx_r);
  assign den_nxt = XW'(p_dax_dby_r) - XW'(p_day_dbx_r);

  // strictly on one side: both positive or both negative
  assign same_ab = (!cr_abc[XW-1] && (cr_abc != '0) && !cr_abe[XW-1] && (cr_abe != '0)) ||
                   (cr_abc[XW-1] && cr_abe[XW-1]);
  assign same_ce = (!num_nxt[XW-1] && (num_nxt != '0) && !cr_ceb[XW-1] && (cr_ceb != '0)) ||
                   (num_nxt[XW-1] && cr_ceb[XW-1]);

  assign flags_nxt.hit         = !same_ab && !same_ce;
  assign flags_nxt.point_valid = !same_ab && !same_ce && (den_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    flags_r  <= flags_nxt;
    s3_ax_r  <= s2_ax_r;
    s3_ay_r  <= s2_ay_r;
    s3_dax_r <= s2_dax_r;
    s3_day_r <= s2_day_r;
    den_r    <= den_nxt;
    num_r    <= num_nxt;
  end

  assign valid_o = s3_vld_r;
  assign flags_o = flags_r;
  assign ax_o    = s3_ax_r;
  assign ay_o    = s3_ay_r;
  assign dax_o   = s3_dax_r;
  assign day_o   = s3_day_r;
  assign den_o   = den_r;
  assign num_o   = num_r;

endmodule

FILE: hw/rtl/sip_scale.sv
// scaling stages: point numerators, magnitudes and divider setup
module sip_scale #(
  parameter int unsigned COORD_BITS = sip_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    valid_i,
  input  sip_pkg::sip_flags_t                                     flags_i,
  input  logic signed [COORD_BITS-1:0]                            ax_i,
  input  logic signed [COORD_BITS-1:0]                            ay_i,
  input  logic signed [COORD_BITS:0]                              dax_i,
  input  logic signed [COORD_BITS:0]                              day_i,
  input  logic signed [2*COORD_BITS+2:0]                          den_i,
  input  logic signed [2*COORD_BITS+2:0]                          num_i,
  output logic                                                    valid_o,
  output sip_pkg::sip_flags_t                                     flags_o,
  output logic [2*COORD_BITS+1:0]                                 dmag_o,
  output logic [sip_pkg::LANES-1:0]                               neg_o,
  output logic [sip_pkg::LANES-1:0][2*COORD_BITS+1:0]             rem_o,
  output logic [sip_pkg::LANES-1:0][COORD_BITS+FRAC_BITS-1:0]     low_o
);
  import sip_pkg::*;

  localparam int unsigned MW = 2 * COORD_BITS + 2;
  localparam int unsigned XW = 2 * COORD_BITS + 3;
  localparam int unsigned VW = 3 * COORD_BITS + 5;
  localparam int unsigned Q  = COORD_BITS + FRAC_BITS;
  localparam int unsigned SW = VW + FRAC_BITS;

  // stage 4: base times den and direction times num
  logic                 s4_vld_r;
  sip_flags_t           s4_flags_r;
  logic signed [XW-1:0] s4_den_r;
  logic signed [VW-1:0] ma_nxt [LANES];
  logic signed [VW-1:0] mb_nxt [LANES];
  logic signed [VW-1:0] s4_ma_r [LANES];
  logic signed [VW-1:0] s4_mb_r [LANES];

  assign ma_nxt[LANE_X] = ax_i * den_i;
  assign ma_nxt[LANE_Y] = ay_i * den_i;
  assign mb_nxt[LANE_X] = dax_i * num_i;
  assign mb_nxt[LANE_Y] = day_i * num_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    s4_flags_r <= flags_i;
    s4_den_r   <= den_i;
    s4_ma_r    <= ma_nxt;
    s4_mb_r    <= mb_nxt;
  end

  // stage 5: numerator sums and divisor magnitude
  logic                 s5_vld_r;
  sip_flags_t           s5_flags_r;
  logic signed [VW-1:0] v_nxt [LANES];
  logic signed [VW-1:0] s5_v_r [LANES];
  logic [MW-1:0]        dmag_nxt, s5_dmag_r;
  logic                 s5_dneg_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      v_nxt[l] = s4_ma_r[l] + s4_mb_r[l];
    end
  end

  assign dmag_nxt = s4_den_r[XW-1] ? MW'(-s4_den_r) : MW'(s4_den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_flags_r <= s4_flags_r;
    s5_v_r     <= v_nxt;
    s5_dmag_r  <= dmag_nxt;
    s5_dneg_r  <= s4_den_r[XW-1];
  end

  // stage 6: numerator magnitude, scaled and split for the divider
  logic                          s6_vld_r;
  sip_flags_t                    s6_flags_r;
  logic [MW-1:0]                 s6_dmag_r;
  logic [LANES-1:0]              neg_nxt, s6_neg_r;
  logic [LANES-1:0][VW-1:0]      vmag;
  logic [LANES-1:0][SW-1:0]      nsh;
  logic [LANES-1:0][MW-1:0]      rem_nxt, s6_rem_r;
  logic [LANES-1:0][Q-1:0]       low_nxt, s6_low_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      vmag[l]    = s5_v_r[l][VW-1] ? VW'(-s5_v_r[l]) : VW'(s5_v_r[l]);
      nsh[l]     = SW'(vmag[l]) << FRAC_BITS;
      rem_nxt[l] = nsh[l][Q +: MW];
      low_nxt[l] = nsh[l][Q-1:0];
      neg_nxt[l] = s5_v_r[l][VW-1] ^ s5_dneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_flags_r <= s5_flags_r;
    s6_dmag_r  <= s5_dmag_r;
    s6_neg_r   <= neg_nxt;
    s6_rem_r   <= rem_nxt;
    s6_low_r   <= low_nxt;
  end

  assign valid_o = s6_vld_r;
  assign flags_o = s6_flags_r;
  assign dmag_o  = s6_dmag_r;
  assign neg_o   = s6_neg_r;
  assign rem_o   = s6_rem_r;
  assign low_o   = s6_low_r;

endmodule

FILE: hw/rtl/sip_div.sv
// pipelined restoring divider, one quotient bit per stage, x and y lanes
module sip_div #(
  parameter int unsigned COORD_BITS = sip_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    valid_i,
  input  sip_pkg::sip_flags_t                                     flags_i,
  input  logic [2*COORD_BITS+1:0]                                 dmag_i,
  input  logic [sip_pkg::LANES-1:0]                               neg_i,
  input  logic [sip_pkg::LANES-1:0][2*COORD_BITS+1:0]             rem_i,
  input  logic [sip_pkg::LANES-1:0][COORD_BITS+FRAC_BITS-1:0]     low_i,
  output logic                                                    valid_o,
  output sip_pkg::sip_flags_t                                     flags_o,
  output logic [sip_pkg::LANES-1:0]                               neg_o,
  output logic [sip_pkg::LANES-1:0][COORD_BITS+FRAC_BITS-1:0]     quo_o
);
  import sip_pkg::*;

  localparam int unsigned MW = 2 * COORD_BITS + 2;
  localparam int unsigned Q  = COORD_BITS + FRAC_BITS;

  logic                          vld_r   [Q];
  sip_flags_t                    flags_r [Q];
  logic [MW-1:0]                 dmag_r  [Q];
  logic [LANES-1:0]              neg_r   [Q];
  logic [LANES-1:0][Q-1:0]       quo_r   [Q];
  logic [LANES-1:0][MW-1:0]      rem_r   [Q-1];
  logic [LANES-1:0][Q-1:0]       low_r   [Q-1];

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic                     src_vld;
    sip_flags_t               src_flags;
    logic [MW-1:0]            src_dmag;
    logic [LANES-1:0]         src_neg;
    logic [LANES-1:0][MW-1:0] src_rem, rem_nxt;
    logic [LANES-1:0][Q-1:0]  src_low, src_quo, low_nxt, quo_nxt;
    logic [LANES-1:0][MW:0]   trial, diff;
    logic [LANES-1:0]         ge;

    if (k == 0) begin : g_head
      assign src_vld   = valid_i;
      assign src_flags = flags_i;
      assign src_dmag  = dmag_i;
      assign src_neg   = neg_i;
      assign src_rem   = rem_i;
      assign src_low   = low_i;
      assign src_quo   = '0;
    end else begin : g_body
      assign src_vld   = vld_r[k-1];
      assign src_flags = flags_r[k-1];
      assign src_dmag  = dmag_r[k-1];
      assign src_neg   = neg_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_low   = low_r[k-1];
      assign src_quo   = quo_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]   = {src_rem[l], src_low[l][Q-1]};
        diff[l]    = trial[l] - (MW+1)'(src_dmag);
        ge[l]      = trial[l] >= (MW+1)'(src_dmag);
        rem_nxt[l] = ge[l] ? diff[l][MW-1:0] : trial[l][MW-1:0];
        low_nxt[l] = src_low[l] << 1;
        quo_nxt[l] = {src_quo[l][Q-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      flags_r[k] <= src_flags;
      dmag_r[k]  <= src_dmag;
      neg_r[k]   <= src_neg;
      quo_r[k]   <= quo_nxt;
    end

    if (k < Q - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_nxt;
      end
    end
  end

  assign valid_o = vld_r[Q-1];
  assign flags_o = flags_r[Q-1];
  assign neg_o   = neg_r[Q-1];
  assign quo_o   = quo_r[Q-1];

endmodule

FILE: hw/rtl/segment_intersection_point.sv
// segment intersection top level: exact hit test and fixed point crossing point
//
// A request carries two segments, A (start, end) and B (start, end), as signed
// integer coordinates on the in_ ports. It is taken at a clock edge with start
// high and busy low. busy is high only while rst_n is low; otherwise a request
// may be given in every cycle.
// Each request gives one result on the out_ports, marked by out_valid for one
// cycle. Throughput is one request per cycle; the divider stages, one quotient
// bit each, make up most of the latency.
// out_hit flags touching or crossing segments, and any collinear pair.
// out_point_valid adds a nonzero direction cross product; out_cross_x and
// out_cross_y then hold the crossing point with FRAC_BITS fraction bits,
// truncated toward zero and clipped to 32 signed bits; otherwise both are zero.
// The receiver cannot stall: a result is gone after its strobe cycle.
// Reset empties the pipeline; requests in flight are dropped.
`include "segment_intersection_point_defines.svh"

module segment_intersection_point #(
  parameter int unsigned COORD_BITS = sip_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_start_x,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_start_y,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_end_x,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_end_y,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_start_x,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_start_y,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_end_x,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_end_y,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic                              out_point_valid,
  output logic signed [sip_pkg::OUT_W-1:0]  out_cross_x,
  output logic signed [sip_pkg::OUT_W-1:0]  out_cross_y
);
  import sip_pkg::*;

  localparam int unsigned Q   = COORD_BITS + FRAC_BITS;
  localparam int unsigned MW  = 2 * COORD_BITS + 2;
  localparam int unsigned XW  = 2 * COORD_BITS + 3;
  localparam int unsigned QX  = ((Q > OUT_W) ? Q : OUT_W) + 1;
  localparam int unsigned LAT = 7 + Q;
  localparam logic [QX-1:0] POS_MAX = QX'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [QX-1:0] NEG_MAG = QX'(64'd1 << (OUT_W - 1));

  logic                           in_take;
  logic                           fr_vld;
  sip_flags_t                     fr_flags;
  logic signed [COORD_BITS-1:0]   fr_ax, fr_ay;
  logic signed [COORD_BITS:0]     fr_dax, fr_day;
  logic signed [XW-1:0]           fr_den, fr_num;
  logic                           sc_vld;
  sip_flags_t                     sc_flags;
  logic [MW-1:0]                  sc_dmag;
  logic [LANES-1:0]               sc_neg;
  logic [LANES-1:0][MW-1:0]       sc_rem;
  logic [LANES-1:0][Q-1:0]        sc_low;
  logic                           dv_vld;
  sip_flags_t                     dv_flags;
  logic [LANES-1:0]               dv_neg;
  logic [LANES-1:0][Q-1:0]        dv_quo;

  assign busy    = !rst_n;
  assign in_take = start && !busy;

  sip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_take),
    .ax_i    (in_seg_a_start_x),
    .ay_i    (in_seg_a_start_y),
    .bx_i    (in_seg_a_end_x),
    .by_i    (in_seg_a_end_y),
    .cx_i    (in_seg_b_start_x),
    .cy_i    (in_seg_b_start_y),
    .ex_i    (in_seg_b_end_x),
    .ey_i    (in_seg_b_end_y),
    .valid_o (fr_vld),
    .flags_o (fr_flags),
    .ax_o    (fr_ax),
    .ay_o    (fr_ay),
    .dax_o   (fr_dax),
    .day_o   (fr_day),
    .den_o   (fr_den),
    .num_o   (fr_num)
  );

  sip_scale #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (fr_vld),
    .flags_i (fr_flags),
    .ax_i    (fr_ax),
    .ay_i    (fr_ay),
    .dax_i   (fr_dax),
    .day_i   (fr_day),
    .den_i   (fr_den),
    .num_i   (fr_num),
    .valid_o (sc_vld),
    .flags_o (sc_flags),
    .dmag_o  (sc_dmag),
    .neg_o   (sc_neg),
    .rem_o   (sc_rem),
    .low_o   (sc_low)
  );

  sip_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sc_vld),
    .flags_i (sc_flags),
    .dmag_i  (sc_dmag),
    .neg_i   (sc_neg),
    .rem_i   (sc_rem),
    .low_i   (sc_low),
    .valid_o (dv_vld),
    .flags_o (dv_flags),
    .neg_o   (dv_neg),
    .quo_o   (dv_quo)
  );

  // sign, clipping and zeroing of the point
  logic [LANES-1:0][QX-1:0]     qx;
  logic [LANES-1:0][OUT_W-1:0]  pt_nxt;
  logic                         out_vld_r, hit_r, pv_r;
  logic signed [OUT_W-1:0]      cx_r, cy_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qx[l] = QX'(dv_quo[l]);
      if (!dv_flags.point_valid) begin
        pt_nxt[l] = '0;
      end else if (dv_neg[l]) begin
        pt_nxt[l] = (qx[l] > NEG_MAG) ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-qx[l]);
      end else begin
        pt_nxt[l] = (qx[l] > POS_MAX) ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(qx[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= dv_flags.hit;
    pv_r  <= dv_flags.point_valid;
    cx_r  <= pt_nxt[LANE_X];
    cy_r  <= pt_nxt[LANE_Y];
  end

  assign out_valid       = out_vld_r;
  assign out_hit         = hit_r;
  assign out_point_valid = pv_r;
  assign out_cross_x     = cx_r;
  assign out_cross_y     = cy_r;

  `SIP_ASSERT_IMPL(a_point_needs_hit, clk, rst_n, out_valid && out_point_valid, out_hit)
  `SIP_ASSERT_IMPL(a_no_point_zero, clk, rst_n, out_valid && !out_point_valid, (out_cross_x == '0) && (out_cross_y == '0))
  `SIP_ASSERT_IMPL(a_fixed_latency, clk, rst_n, start && !busy, ##LAT out_valid)
  `SIP_ASSERT(a_no_spurious, clk, rst_n, out_valid |-> $past(start && !busy, LAT))

endmodule

FILE: tb/tb_segment_intersection_point.sv
// testbench for segment_intersection_point: directed and random segment pairs
module tb_segment_intersection_point;

  localparam int CW           = sip_pkg::COORD_BITS_DEF;
  localparam int FW           = sip_pkg::FRAC_BITS_DEF;
  localparam int OW           = sip_pkg::OUT_W;
  localparam int LATENCY      = 7 + CW + FW;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic signed [CW-1:0] a_sx;
    logic signed [CW-1:0] a_sy;
    logic signed [CW-1:0] a_ex;
    logic signed [CW-1:0] a_ey;
    logic signed [CW-1:0] b_sx;
    logic signed [CW-1:0] b_sy;
    logic signed [CW-1:0] b_ex;
    logic signed [CW-1:0] b_ey;
  } seg_pair_t;

  typedef struct {
    logic                 hit;
    logic                 point_valid;
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
  } crossing_t;

  class crossing_scoreboard;
    crossing_t expected_points[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function int side_of(longint px, longint py, longint qx, longint qy,
                         longint rx, longint ry);
      longint t;
      t = (qx - px) * (ry - py) - (qy - py) * (rx - px);
      return (t > 0) ? 1 : ((t < 0) ? -1 : 0);
    endfunction

    // base + dir * num / den in fixed point, truncated toward zero, clipped
    function logic signed [OW-1:0] fixed_coord(longint base, longint dir, longint num,
                                               longint den);
      logic signed [127:0] b, r, n, d, v, q;
      longint              hi_lim, lo_lim;
      hi_lim = 64'sd2147483647;
      lo_lim = -64'sd2147483648;
      b = base;
      r = dir;
      n = num;
      d = den;
      v = b * d + r * n;
      v = v <<< FW;
      q = v / d;
      if (q > hi_lim) return 32'sh7fffffff;
      if (q < lo_lim) return 32'sh80000000;
      return q[OW-1:0];
    endfunction

    function crossing_t predict_crossing(seg_pair_t s);
      longint    ax, ay, bx, by, cx, cy, ex, ey, dax, day, dbx, dby, den, num;
      int        o1, o2, o3, o4;
      crossing_t r;
      ax = s.a_sx; ay = s.a_sy; bx = s.a_ex; by = s.a_ey;
      cx = s.b_sx; cy = s.b_sy; ex = s.b_ex; ey = s.b_ey;
      dax = bx - ax; day = by - ay; dbx = ex - cx; dby = ey - cy;
      o1 = side_of(ax, ay, bx, by, cx, cy);
      o2 = side_of(ax, ay, bx, by, ex, ey);
      o3 = side_of(cx, cy, ex, ey, ax, ay);
      o4 = side_of(cx, cy, ex, ey, bx, by);
      den = dax * dby - day * dbx;
      num = (cx - ax) * dby - (cy - ay) * dbx;
      r.hit = (o1 * o2 <= 0) && (o3 * o4 <= 0);
      r.point_valid = r.hit && (den != 0);
      r.x = '0;
      r.y = '0;
      if (r.point_valid) begin
        r.x = fixed_coord(ax, dax, num, den);
        r.y = fixed_coord(ay, day, num, den);
      end
      return r;
    endfunction

    function void note_request(seg_pair_t s);
      expected_points.push_back(predict_crossing(s));
    endfunction

    function void check_result(logic hit, logic point_valid, logic signed [OW-1:0] x,
                               logic signed [OW-1:0] y);
      crossing_t e;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: hit=%0d pv=%0d x=%0d y=%0d", hit, point_valid, x, y);
        return;
      end
      e = expected_points.pop_front();
      if (hit !== e.hit || point_valid !== e.point_valid || x !== e.x || y !== e.y) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected hit=%0d pv=%0d x=%0d y=%0d, %s%0d pv=%0d x=%0d y=%0d",
                   e.hit, e.point_valid, e.x, e.y, "got hit=", hit, point_valid, x, y);
      end
    endfunction

    function int outstanding();
      return expected_points.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] in_seg_a_start_x = '0;
  logic signed [CW-1:0] in_seg_a_start_y = '0;
  logic signed [CW-1:0] in_seg_a_end_x = '0;
  logic signed [CW-1:0] in_seg_a_end_y = '0;
  logic signed [CW-1:0] in_seg_b_start_x = '0;
  logic signed [CW-1:0] in_seg_b_start_y = '0;
  logic signed [CW-1:0] in_seg_b_end_x = '0;
  logic signed [CW-1:0] in_seg_b_end_y = '0;
  logic                 out_valid;
  logic                 out_hit;
  logic                 out_point_valid;
  logic signed [OW-1:0] out_cross_x;
  logic signed [OW-1:0] out_cross_y;

  crossing_scoreboard sb;
  int                 cycles = 0;

  segment_intersection_point dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_seg_a_start_x (in_seg_a_start_x),
    .in_seg_a_start_y (in_seg_a_start_y),
    .in_seg_a_end_x   (in_seg_a_end_x),
    .in_seg_a_end_y   (in_seg_a_end_y),
    .in_seg_b_start_x (in_seg_b_start_x),
    .in_seg_b_start_y (in_seg_b_start_y),
    .in_seg_b_end_x   (in_seg_b_end_x),
    .in_seg_b_end_y   (in_seg_b_end_y),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_point_valid  (out_point_valid),
    .out_cross_x      (out_cross_x),
    .out_cross_y      (out_cross_y)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    seg_pair_t s;
    if (rst_n) begin
      if (start && !busy) begin
        s.a_sx = in_seg_a_start_x; s.a_sy = in_seg_a_start_y;
        s.a_ex = in_seg_a_end_x;   s.a_ey = in_seg_a_end_y;
        s.b_sx = in_seg_b_start_x; s.b_sy = in_seg_b_start_y;
        s.b_ex = in_seg_b_end_x;   s.b_ey = in_seg_b_end_y;
        sb.note_request(s);
      end
      if (out_valid)
        sb.check_result(out_hit, out_point_valid, out_cross_x, out_cross_y);
    end
  end

  function automatic int rnd_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic seg_pair_t pair_of(int c[8]);
    seg_pair_t s;
    s.a_sx = CW'(c[0]); s.a_sy = CW'(c[1]); s.a_ex = CW'(c[2]); s.a_ey = CW'(c[3]);
    s.b_sx = CW'(c[4]); s.b_sy = CW'(c[5]); s.b_ex = CW'(c[6]); s.b_ey = CW'(c[7]);
    return s;
  endfunction

  function automatic seg_pair_t random_pair();
    int c[8];
    int kind, px, py, dx, dy, k;
    kind = $urandom_range(9, 0);
    unique case (kind)
      0, 1, 2: begin
        foreach (c[i]) c[i] = rnd_in(-32768, 32767);
      end
      3, 4: begin
        foreach (c[i]) c[i] = rnd_in(-4, 4);
      end
      5, 6: begin
        // both segments through one lattice point
        px = rnd_in(-16000, 16000);
        py = rnd_in(-16000, 16000);
        dx = rnd_in(-16000, 16000);
        dy = rnd_in(-16000, 16000);
        c[0] = px - dx; c[1] = py - dy; c[2] = px + dx; c[3] = py + dy;
        dx = rnd_in(-16000, 16000);
        dy = rnd_in(-16000, 16000);
        c[4] = px + dx; c[5] = py + dy; c[6] = px - dx; c[7] = py - dy;
      end
      7: begin
        // all four ends on one line
        px = rnd_in(-1000, 1000);
        py = rnd_in(-1000, 1000);
        dx = rnd_in(-100, 100);
        dy = rnd_in(-100, 100);
        for (int j = 0; j < 4; j++) begin
          k = rnd_in(-5, 5);
          c[2*j] = px + k * dx;
          c[2*j+1] = py + k * dy;
        end
      end
      8: begin
        foreach (c[i]) c[i] = rnd_in(-32768, 32767);
        if ($urandom_range(1, 0) == 0) begin
          c[4] = c[2]; c[5] = c[3];
        end else begin
          c[6] = c[0]; c[7] = c[1];
        end
      end
      default: begin
        foreach (c[i]) c[i] = rnd_in(-200, 200);
      end
    endcase
    return pair_of(c);
  endfunction

  task automatic drive_fields(seg_pair_t s);
    in_seg_a_start_x <= s.a_sx;
    in_seg_a_start_y <= s.a_sy;
    in_seg_a_end_x   <= s.a_ex;
    in_seg_a_end_y   <= s.a_ey;
    in_seg_b_start_x <= s.b_sx;
    in_seg_b_start_y <= s.b_sy;
    in_seg_b_end_x   <= s.b_ex;
    in_seg_b_end_y   <= s.b_ey;
  endtask

  task automatic drive_request(seg_pair_t s);
    start <= 1'b1;
    drive_fields(s);
    do @(posedge clk); while (busy);
  endtask

  // idle cycles carry junk on the request fields
  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      drive_fields(random_pair());
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int sent, burst, gap;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    drive_request(pair_of('{0, 0, 0, 0, 0, 0, 0, 0}));
    drive_request(pair_of('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}));
    drive_request(pair_of('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
    drive_request(pair_of('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}));
    drive_request(pair_of('{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768}));
    drive_request(pair_of('{0, 0, 3, 0, 1, -1, 2, 2}));
    drive_request(pair_of('{0, 0, -3, 0, -1, 1, -2, -2}));
    drive_request(pair_of('{0, 0, 4, 0, 0, 1, 4, 1}));
    drive_request(pair_of('{0, 0, 4, 4, 2, 2, 6, 6}));
    drive_request(pair_of('{0, 0, 1, 1, 5, 5, 9, 9}));
    drive_request(pair_of('{2, 2, 2, 2, 0, 0, 4, 4}));
    drive_request(pair_of('{5, 0, 5, 0, 0, 0, 4, 4}));
    drive_request(pair_of('{7, 7, 7, 7, 7, 7, 7, 7}));
    drive_request(pair_of('{1, 2, 1, 2, 3, 4, 3, 4}));
    drive_request(pair_of('{0, 0, 4, 0, 4, 0, 4, 5}));
    drive_request(pair_of('{0, 0, 4, 0, 2, 0, 2, 7}));
    drive_request(pair_of('{0, 0, 1, 1, 5, 0, 4, 1}));
    drive_request(pair_of('{-32768, 0, 32767, 0, 0, -32768, 1, 32767}));
    drive_request(pair_of('{-32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767}));
    drive_request(pair_of('{32767, 32767, 32767, -32768, -32768, 32767, 32767, 32767}));
    drive_request(pair_of('{-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32765}));
    pause(3);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(5, 0) == 0) ? 80 : int'($urandom_range(20, 1));
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        drive_request(random_pair());
        sent++;
      end
      gap = ($urandom_range(7, 0) == 0) ? int'($urandom_range(12, 5))
                                        : int'($urandom_range(3, 0));
      pause(gap);
    end
    pause(1);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sip_pkg.sv
hw/rtl/sip_front.sv
hw/rtl/sip_scale.sv
hw/rtl/sip_div.sv
hw/rtl/segment_intersection_point.sv
tb/tb_segment_intersection_point.sv
